>>> design/cll_pkg.sv
// ----------------------------------------------------------------------------
// cll_pkg
// Shared types, constants and helpers for the cursor linked list engine.
// ----------------------------------------------------------------------------
package cll_pkg;

	// Number of node slots in the store.
	localparam int CAPACITY = 64;
	// A slot index holds 0..CAPACITY, where CAPACITY itself is the null marker.
	localparam int SLOT_W = $clog2(CAPACITY + 1);
	// Address width of the slot memories.
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int VAL_W = 32;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [IDX_W-1:0] idx_t;

	localparam slot_t NIL = slot_t'(CAPACITY);

	// Request kinds.
	typedef enum logic [2:0] {
		K_NEXT       = 3'd0,
		K_PREV       = 3'd1,
		K_INS_AFTER  = 3'd2,
		K_INS_BEFORE = 3'd3,
		K_READ       = 3'd4,
		K_DELETE     = 3'd5
	} kind_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LINK,
		ST_WR2,
		ST_VAL,
		ST_DONE
	} st_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;     // take the request and read the cursor links
		logic link;      // first update step
		logic wr2;       // second link write of an insert or delete
		logic val_rd;    // read the value under the cursor
		logic load_out;  // load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic wr2_needed;
		logic out_free;
	} sts_t;

	// True when a slot index points at a real node.
	function automatic logic live(slot_t s);
		return s < NIL;
	endfunction

endpackage

>>> design/cll_ctrl.sv
// ----------------------------------------------------------------------------
// cll_ctrl
// Request sequencer: steps one request through lookup, link updates, value
// fetch and result hand-off.
// ----------------------------------------------------------------------------
module cll_ctrl
	import cll_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output cmd_t cmd,
	input  sts_t sts
);

	st_t state_q;
	st_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nx = ST_LINK;
				end
			end
			ST_LINK: begin
				state_nx = sts.wr2_needed ? ST_WR2 : ST_VAL;
			end
			ST_WR2: begin
				state_nx = ST_VAL;
			end
			ST_VAL: begin
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.start = s_tvalid;
			end
			ST_LINK: begin
				cmd.link = 1'b1;
			end
			ST_WR2: begin
				cmd.wr2 = 1'b1;
			end
			ST_VAL: begin
				cmd.val_rd = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> design/cll_dpath.sv
// ----------------------------------------------------------------------------
// cll_dpath
// List datapath: slot memories for values and links, list pointers, slot
// allocator and the result register.
// ----------------------------------------------------------------------------
module cll_dpath
	import cll_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic [2:0]              in_kind,
	input  logic signed [VAL_W-1:0] in_value,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [VAL_W-1:0]        m_tdata,
	output logic [1:0]              m_tuser
);

	// Slot memories.
	logic [VAL_W-1:0] val_mem [CAPACITY];
	slot_t            nxt_mem [CAPACITY];
	slot_t            prv_mem [CAPACITY];

	// List pointers and allocator state.
	slot_t head_q, tail_q, cur_q, free_q, fresh_q;

	// Per-request working registers.
	logic [2:0]              kind_q;
	logic signed [VAL_W-1:0] value_q;
	slot_t                   n_q, nx_q, pv_q, cold_q;
	logic                    ok_q;

	// Registered memory read data.
	slot_t            nxt_rd_a_q, nxt_rd_b_q, prv_rd_q;
	logic [VAL_W-1:0] val_rd_q;

	// Result register.
	logic             out_valid_q;
	logic [VAL_W-1:0] out_data_q;
	logic [1:0]       out_user_q;

	// Write ports.
	logic             val_we, nxt_we, prv_we;
	slot_t            val_wa, nxt_wa, prv_wa;
	logic [VAL_W-1:0] val_wd;
	slot_t            nxt_wd, prv_wd;

	// Decoded request and allocator view during the first update step.
	logic  is_ins, is_after, is_del, cur_live, free_live, slot_ok;
	slot_t new_slot;

	assign is_ins    = (kind_q == K_INS_AFTER) || (kind_q == K_INS_BEFORE);
	assign is_after  = (kind_q == K_INS_AFTER);
	assign is_del    = (kind_q == K_DELETE);
	assign cur_live  = live(cur_q);
	assign free_live = live(free_q);
	assign slot_ok   = free_live || (fresh_q < NIL);
	assign new_slot  = free_live ? free_q : fresh_q;

	assign sts.wr2_needed = cur_live && ((is_ins && slot_ok) || is_del);
	assign sts.out_free   = !out_valid_q || m_tready;

	// Write port selection for both update steps.
	always_comb begin
		val_we = 1'b0;
		val_wa = new_slot;
		val_wd = value_q;
		nxt_we = 1'b0;
		nxt_wa = new_slot;
		nxt_wd = NIL;
		prv_we = 1'b0;
		prv_wa = new_slot;
		prv_wd = NIL;
		if (cmd.link) begin
			if (is_ins && slot_ok) begin
				// Fill in the new node; its neighbors are fixed up next step.
				val_we = 1'b1;
				nxt_we = 1'b1;
				prv_we = 1'b1;
				nxt_wd = !cur_live ? NIL : (is_after ? nxt_rd_a_q : cur_q);
				prv_wd = !cur_live ? NIL : (is_after ? cur_q : prv_rd_q);
			end else if (is_del && cur_live) begin
				// Unlink the cursor node from both neighbors.
				nxt_we = live(prv_rd_q);
				nxt_wa = prv_rd_q;
				nxt_wd = nxt_rd_a_q;
				prv_we = live(nxt_rd_a_q);
				prv_wa = nxt_rd_a_q;
				prv_wd = prv_rd_q;
			end
		end else if (cmd.wr2) begin
			if (is_del) begin
				// Push the freed slot onto the free list.
				nxt_we = 1'b1;
				nxt_wa = cold_q;
				nxt_wd = free_q;
			end else if (is_after) begin
				nxt_we = 1'b1;
				nxt_wa = cur_q;
				nxt_wd = n_q;
				prv_we = live(nx_q);
				prv_wa = nx_q;
				prv_wd = n_q;
			end else begin
				prv_we = 1'b1;
				prv_wa = cur_q;
				prv_wd = n_q;
				nxt_we = live(pv_q);
				nxt_wa = pv_q;
				nxt_wd = n_q;
			end
		end
	end

	// Memories: one write port each, registered reads.
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_wa[IDX_W-1:0]] <= val_wd;
		end
		if (nxt_we) begin
			nxt_mem[nxt_wa[IDX_W-1:0]] <= nxt_wd;
		end
		if (prv_we) begin
			prv_mem[prv_wa[IDX_W-1:0]] <= prv_wd;
		end
		if (cmd.start) begin
			nxt_rd_a_q <= nxt_mem[cur_q[IDX_W-1:0]];
			nxt_rd_b_q <= nxt_mem[free_q[IDX_W-1:0]];
			prv_rd_q   <= prv_mem[cur_q[IDX_W-1:0]];
		end
		if (cmd.val_rd) begin
			val_rd_q <= val_mem[cur_q[IDX_W-1:0]];
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q  <= in_kind;
			value_q <= in_value;
		end
		if (cmd.link) begin
			n_q    <= new_slot;
			nx_q   <= nxt_rd_a_q;
			pv_q   <= prv_rd_q;
			cold_q <= cur_q;
			case (kind_q)
				K_NEXT:       ok_q <= cur_live && live(nxt_rd_a_q);
				K_PREV:       ok_q <= cur_live && live(prv_rd_q);
				K_INS_AFTER:  ok_q <= slot_ok;
				K_INS_BEFORE: ok_q <= slot_ok;
				K_READ:       ok_q <= cur_live;
				K_DELETE:     ok_q <= cur_live;
				default:      ok_q <= 1'b0;
			endcase
		end
	end

	// List pointers and allocator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NIL;
			tail_q  <= NIL;
			cur_q   <= NIL;
			free_q  <= NIL;
			fresh_q <= '0;
		end else if (cmd.link) begin
			case (kind_q)
				K_NEXT: begin
					if (cur_live && live(nxt_rd_a_q)) begin
						cur_q <= nxt_rd_a_q;
					end
				end
				K_PREV: begin
					if (cur_live && live(prv_rd_q)) begin
						cur_q <= prv_rd_q;
					end
				end
				K_INS_AFTER, K_INS_BEFORE: begin
					if (slot_ok) begin
						if (free_live) begin
							free_q <= nxt_rd_b_q;
						end else begin
							fresh_q <= fresh_q + slot_t'(1);
						end
						if (!cur_live) begin
							head_q <= new_slot;
							tail_q <= new_slot;
							cur_q  <= new_slot;
						end
					end
				end
				K_DELETE: begin
					if (cur_live) begin
						if (!live(prv_rd_q)) begin
							head_q <= nxt_rd_a_q;
						end
						if (!live(nxt_rd_a_q)) begin
							tail_q <= prv_rd_q;
						end
						cur_q <= live(nxt_rd_a_q) ? nxt_rd_a_q : prv_rd_q;
					end
				end
				default: begin
					cur_q <= cur_q;
				end
			endcase
		end else if (cmd.wr2) begin
			if (is_del) begin
				free_q <= cold_q;
			end else if (is_after) begin
				if (!live(nx_q)) begin
					tail_q <= n_q;
				end
			end else if (!live(pv_q)) begin
				head_q <= n_q;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_user_q <= {cur_live, ok_q};
			out_data_q <= cur_live ? val_rd_q : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

>>> design/cursor_linked_list_engine.sv
// ----------------------------------------------------------------------------
// cursor_linked_list_engine
// Fixed-capacity doubly linked list of signed 32-bit values with a cursor.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata                 tuser
//  s_*       in         [31:0] value          [2:0] kind
//  m_*       out        [31:0] cur_value      [0] ok, [1] has_current
//
// One request is taken at a time. Move, read and unused requests go from the
// link step straight to the value fetch; inserts and deletes on a live cursor
// (inserts also need a free slot) add a second write step, because their link
// updates need a second write to the link memories, which have one write port
// each. The next request is taken only once the result has been loaded into
// the output register.
// A finished result waits in the output register; a stalled m_tready holds
// only the result and the sequencer's final step, never the memories.
// Reset is asynchronous and empties the list at once; the slot memories need
// no clearing, since a slot is always written before it is read.
//
module cursor_linked_list_engine
	import cll_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [2:0]  s_tuser,   // [2:0] kind
	// Result channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] cur_value
	output logic [1:0]  m_tuser    // [0] ok, [1] has_current
);

	// The controller sequences each request; the datapath holds the list.
	cmd_t cmd;
	sts_t sts;

	cll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The value field is carried signed inside the datapath.
	cll_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_kind  (s_tuser),
		.in_value ($signed(s_tdata)),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> design/cll_chk.sv
// ----------------------------------------------------------------------------
// cll_chk
// Port-level checks for the cursor linked list engine.
// ----------------------------------------------------------------------------
module cll_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Without a current element the value reads as zero.
	a_no_cur_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata == 32'd0)
		else $error("value shown without a current element");

	// Only one request is in flight at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	// A new result only appears at the end of a request's work.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a request");

endmodule

bind cursor_linked_list_engine cll_chk u_chk (.*);
